// ===== rtl/cicd_pkg.sv =====
// Shared constants, register codes and stage control type for the CIC decimator.
package cicd_pkg;

  // Default sizing of the stage pipeline
  localparam int MAX_STAGES_DEF = 6;
  localparam int MAX_DELAY_DEF  = 2;

  // Field and register widths
  localparam int DATA_W     = 32;
  localparam int DECIM_W    = 16;
  localparam int STAGES_W   = 3;
  localparam int DELAY_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [DECIM_W-1:0]  DECIM_RST  = 16'd8;
  localparam logic [STAGES_W-1:0] STAGES_RST = 3'd3;
  localparam logic [DELAY_W-1:0]  DELAY_RST  = 2'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIM  = 2'd0,
    CFG_STAGES = 2'd1,
    CFG_DELAY  = 2'd2
  } cfg_reg_t;

  // Per-stage control: take loads the stage, active enables its arithmetic
  typedef struct packed {
    logic take;
    logic active;
  } stage_ctl_t;

endpackage

// ===== rtl/cic_multistage_decimator_core.sv =====
// CIC decimator top level: integrator pipeline, decimation stage, comb pipeline.
// Registers from an accepted sample to out_tvalid:
// one register per integrator, one for the decimation phase, one per comb, one output.
// One sample per cycle unless the output stalls; one adder or subtractor per stage.
// Non-decimated beats drop at the phase stage; a stall fills combs, then integrators.
// Reset (rst_n low, synchronous) clears accumulators, delay lines, phase and registers.
module cic_multistage_decimator_core #(
  parameter int MAX_STAGES = cicd_pkg::MAX_STAGES_DEF,
  parameter int MAX_DELAY  = cicd_pkg::MAX_DELAY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream; tdata: [31:0] sample
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cicd_pkg::DATA_W-1:0]     in_tdata,
  // result stream; tdata: [31:0] filtered
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cicd_pkg::DATA_W-1:0]     out_tdata,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cicd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cicd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DSEL_W = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;

  logic [cicd_pkg::DECIM_W-1:0]  decim_r;
  logic [cicd_pkg::STAGES_W-1:0] stages_r;
  logic [cicd_pkg::DELAY_W-1:0]  delay_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r  <= cicd_pkg::DECIM_RST;
      stages_r <= cicd_pkg::STAGES_RST;
      delay_r  <= cicd_pkg::DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cicd_pkg::cfg_reg_t'(cfg_index))
        cicd_pkg::CFG_DECIM:  decim_r  <= cfg_data[cicd_pkg::DECIM_W-1:0];
        cicd_pkg::CFG_STAGES: stages_r <= cfg_data[cicd_pkg::STAGES_W-1:0];
        cicd_pkg::CFG_DELAY:  delay_r  <= cfg_data[cicd_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // comb tap select: R clamped to 1..MAX_DELAY, minus one
  logic [DSEL_W-1:0] dly_sel;
  always_comb begin
    priority if (delay_r == '0) begin
      dly_sel = '0;
    end else if (int'(delay_r) > MAX_DELAY) begin
      dly_sel = DSEL_W'(MAX_DELAY - 1);
    end else begin
      dly_sel = DSEL_W'(int'(delay_r) - 1);
    end
  end

  // token chains; index 0 is the stage's feed
  logic [MAX_STAGES:0]           ivld;
  logic [cicd_pkg::DATA_W-1:0]   idat [MAX_STAGES+1];
  logic [MAX_STAGES:0]           cvld;
  logic [cicd_pkg::DATA_W-1:0]   cdat [MAX_STAGES+1];
  logic [MAX_STAGES:0]           i_chain;
  logic [MAX_STAGES:0]           c_chain;
  cicd_pkg::stage_ctl_t          i_ctl [MAX_STAGES];
  cicd_pkg::stage_ctl_t          c_ctl [MAX_STAGES];

  logic                          out_valid_r;
  logic [cicd_pkg::DATA_W-1:0]   out_data_r;
  logic                          out_rdy;
  logic                          dv_r;
  logic [cicd_pkg::DATA_W-1:0]   ddata_r;
  logic                          d_rdy;
  logic [cicd_pkg::DECIM_W-1:0]  phase_r;
  logic [cicd_pkg::DECIM_W:0]    phase_inc;
  logic [cicd_pkg::DECIM_W:0]    m_act;
  logic                          hit;

  assign ivld[0] = in_tvalid;
  assign idat[0] = in_tdata;
  assign cvld[0] = dv_r;
  assign cdat[0] = ddata_r;

  // ready ripples back: a stage loads when empty or when its successor loads
  assign out_rdy             = !out_valid_r || out_tready;
  assign c_chain[MAX_STAGES] = out_rdy;
  assign d_rdy               = !dv_r || c_chain[0];
  assign i_chain[MAX_STAGES] = d_rdy;
  assign in_tready           = i_chain[0];

  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_stage
    assign i_chain[i]     = !ivld[i+1] || i_chain[i+1];
    assign c_chain[i]     = !cvld[i+1] || c_chain[i+1];
    // stage 0 is always in use; stages at or past the count only pass data
    assign i_ctl[i].take   = i_chain[i];
    assign i_ctl[i].active = (i == 0) || (int'(stages_r) > i);
    assign c_ctl[i].take   = c_chain[i];
    assign c_ctl[i].active = (i == 0) || (int'(stages_r) > i);

    cicd_integ_stage u_integ (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (i_ctl[i]),
      .in_valid  (ivld[i]),
      .in_data   (idat[i]),
      .tok_valid (ivld[i+1]),
      .tok_data  (idat[i+1])
    );

    cicd_comb_stage #(
      .MAX_DELAY (MAX_DELAY),
      .DSEL_W    (DSEL_W)
    ) u_comb (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (c_ctl[i]),
      .dly_sel   (dly_sel),
      .in_valid  (cvld[i]),
      .in_data   (cdat[i]),
      .tok_valid (cvld[i+1]),
      .tok_data  (cdat[i+1])
    );
  end

  // decimation phase; a zero factor acts as one
  assign m_act     = (decim_r == '0) ? (cicd_pkg::DECIM_W+1)'(1) : {1'b0, decim_r};
  assign phase_inc = {1'b0, phase_r} + (cicd_pkg::DECIM_W+1)'(1);
  assign hit       = phase_inc >= m_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r    <= 1'b0;
      phase_r <= '0;
    end else if (d_rdy) begin
      dv_r <= ivld[MAX_STAGES] && hit;
      if (ivld[MAX_STAGES]) begin
        phase_r <= hit ? '0 : phase_inc[cicd_pkg::DECIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_rdy && ivld[MAX_STAGES]) begin
      ddata_r <= idat[MAX_STAGES];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= cvld[MAX_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && cvld[MAX_STAGES]) begin
      out_data_r <= cdat[MAX_STAGES];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/cicd_integ_stage.sv =====
// One integrator stage: a wrapping accumulator with a token register behind it.
module cicd_integ_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cicd_pkg::stage_ctl_t      ctl,
  input  logic                      in_valid,
  input  logic [cicd_pkg::DATA_W-1:0] in_data,
  output logic                      tok_valid,
  output logic [cicd_pkg::DATA_W-1:0] tok_data
);

  logic                        valid_r;
  logic [cicd_pkg::DATA_W-1:0] acc_r;
  logic [cicd_pkg::DATA_W-1:0] data_r;
  logic [cicd_pkg::DATA_W-1:0] sum;

  assign sum = acc_r + in_data;

  // accumulator and token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      acc_r   <= '0;
    end else if (ctl.take) begin
      valid_r <= in_valid;
      if (in_valid && ctl.active) begin
        acc_r <= sum;
      end
    end
  end

  // inactive stages pass the value on untouched
  always_ff @(posedge clk) begin
    if (ctl.take && in_valid) begin
      data_r <= ctl.active ? sum : in_data;
    end
  end

  assign tok_valid = valid_r;
  assign tok_data  = data_r;

endmodule

// ===== rtl/cicd_comb_stage.sv =====
// One comb stage: subtracts the value from R decimated beats back from its input.
module cicd_comb_stage #(
  parameter int MAX_DELAY = cicd_pkg::MAX_DELAY_DEF,
  parameter int DSEL_W    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cicd_pkg::stage_ctl_t        ctl,
  input  logic [DSEL_W-1:0]           dly_sel,
  input  logic                        in_valid,
  input  logic [cicd_pkg::DATA_W-1:0] in_data,
  output logic                        tok_valid,
  output logic [cicd_pkg::DATA_W-1:0] tok_data
);

  logic                        valid_r;
  logic [cicd_pkg::DATA_W-1:0] dline_r [MAX_DELAY];
  logic [cicd_pkg::DATA_W-1:0] data_r;
  logic [cicd_pkg::DATA_W-1:0] diff;

  assign diff = in_data - dline_r[dly_sel];

  // delay line shifts its full length on each beat into an active stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int k = 0; k < MAX_DELAY; k++) begin
        dline_r[k] <= '0;
      end
    end else if (ctl.take) begin
      valid_r <= in_valid;
      if (in_valid && ctl.active) begin
        for (int k = MAX_DELAY - 1; k > 0; k--) begin
          dline_r[k] <= dline_r[k-1];
        end
        dline_r[0] <= in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && in_valid) begin
      data_r <= ctl.active ? diff : in_data;
    end
  end

  assign tok_valid = valid_r;
  assign tok_data  = data_r;

endmodule

// ===== rtl/cicd_checker.sv =====
// Port-level checks for the CIC decimator, bound to the top level.
module cicd_port_assert (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cicd_pkg::DATA_W-1:0]     out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // no result is pending right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  // with the output side free, the pipeline drains and takes a sample
  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled while output side is free");

  // a result beat waiting on the sink holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output beat changed");

  // configuration writes never wait
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind cic_multistage_decimator_core cicd_port_assert u_cicd_port_assert (.*);

// ===== tb/cicd_checker.sv =====
// Channel monitor for the CIC decimator: predicts every filtered beat and compares it.
`timescale 1ns / 100ps
module cicd_checker
  import cicd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [DATA_W-1:0]     out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_cnt,
  output int                    pending_cnt
);

  localparam int NSTG = MAX_STAGES_DEF;
  localparam int NDLY = MAX_DELAY_DEF;

  // Predictor state, a private copy of the filter
  logic [DATA_W-1:0]        integ_acc [NSTG];
  logic [DATA_W-1:0]        comb_hist [NSTG][NDLY];
  logic [DECIM_W-1:0]       phase_cnt;
  logic [DECIM_W-1:0]       decim_reg;
  logic [STAGES_W-1:0]      stages_reg;
  logic [DELAY_W-1:0]       delay_reg;
  logic signed [DATA_W-1:0] filtered_q [$];

  // One sample through the integrators; on a decimation beat also through the combs
  task automatic integrate_and_decimate(input logic [DATA_W-1:0] x);
    int n_use;
    int r_use;
    int m_use;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] old;
    // out-of-range settings fold into the legal range
    n_use = (stages_reg == 0) ? 1 : ((stages_reg > NSTG) ? NSTG : int'(stages_reg));
    r_use = (delay_reg == 0) ? 1 : ((delay_reg > NDLY) ? NDLY : int'(delay_reg));
    m_use = (decim_reg == 0) ? 1 : int'(decim_reg);
    integ_acc[0] = integ_acc[0] + x;
    for (int n = 1; n < n_use; n++) integ_acc[n] = integ_acc[n] + integ_acc[n-1];
    // phase at or past M-1 (M may have been lowered) fires a result
    if (int'(phase_cnt) + 1 >= m_use) begin
      v = integ_acc[n_use-1];
      phase_cnt = '0;
      for (int n = 0; n < n_use; n++) begin
        old = comb_hist[n][r_use-1];
        // full-depth shift regardless of R
        for (int k = NDLY - 1; k > 0; k--) comb_hist[n][k] = comb_hist[n][k-1];
        comb_hist[n][0] = v;
        v = v - old;
      end
      filtered_q.push_back(v);
    end else begin
      phase_cnt = phase_cnt + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (!rst_n) begin
      foreach (integ_acc[i]) integ_acc[i] = '0;
      foreach (comb_hist[i, j]) comb_hist[i][j] = '0;
      phase_cnt  = '0;
      decim_reg  = DECIM_RST;
      stages_reg = STAGES_RST;
      delay_reg  = DELAY_RST;
      filtered_q.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          $error("filtered: no beat expected, got %0d", $signed(out_tdata));
          mismatch_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (out_tdata !== want) begin
            $error("filtered: expected %0d, got %0d", want, $signed(out_tdata));
            mismatch_cnt++;
          end
        end
      end
      // register writes; unknown index is dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DECIM:  decim_reg  = cfg_data[DECIM_W-1:0];
          CFG_STAGES: stages_reg = cfg_data[STAGES_W-1:0];
          CFG_DELAY:  delay_reg  = cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) integrate_and_decimate(in_tdata);
    end
    pending_cnt = filtered_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the CIC decimator bench: clock, reset, sample and register stimulus, verdict.
`timescale 1ns / 100ps
module testbench;
  import cicd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES  = 2 * MAX_STAGES_DEF + 8;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ROUNDS = 12;
  localparam int ROUND_BEATS   = 70;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int fail_cnt;
  int pending_cnt;

  cic_multistage_decimator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cicd_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatch_cnt (fail_cnt),
    .pending_cnt  (pending_cnt)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver backpressure
  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[cic_multistage_decimator_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample beat, with random idle cycles ahead of it; called and returns at negedge
  task automatic send_sample(input logic [DATA_W-1:0] x);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // one register beat; leaves a quiet step so back-to-back writes stay clean
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending, wait out all results, then let non-decimated beats leave the pipe
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_cnt != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] cfg_word;
    logic [DATA_W-1:0]     sample;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: M=8, N=3, R=1, full-scale and small samples
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);

    // every input decimated, deepest filter, longest delay
    drain_results();
    write_reg(CFG_DECIM, 16'd1);
    write_reg(CFG_STAGES, 16'd6);
    write_reg(CFG_DELAY, 16'd2);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);

    // zero settings fold to one; write to an unknown index changes nothing
    drain_results();
    write_reg(CFG_DECIM, 16'd0);
    write_reg(CFG_STAGES, 16'd0);
    write_reg(CFG_DELAY, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);

    // maximum M, stage count and delay above range: no results
    drain_results();
    write_reg(CFG_DECIM, 16'hFFFF);
    write_reg(CFG_STAGES, 16'hFFFF);
    write_reg(CFG_DELAY, 16'hFFFF);
    send_sample(32'h1234_5678);
    send_sample(32'hFEDC_BA98);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'hFFFF_FFFF);

    // M lowered below the running phase: next sample fires at once
    drain_results();
    write_reg(CFG_DECIM, 16'd2);
    send_sample(32'h0000_0003);
    send_sample(32'hFFFF_FFFD);
    send_sample(32'h4000_0000);

    // random rounds, each with fresh settings and its own idling mode
    for (int rnd = 0; rnd < RANDOM_ROUNDS; rnd++) begin
      case (rnd % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      drain_results();
      // mostly short M; sometimes zero, sometimes 20 to 90, which can exceed the round
      case ($urandom_range(9))
        0:       cfg_word = '0;
        1:       cfg_word = CFG_DATA_W'($urandom_range(20, 90));
        default: cfg_word = CFG_DATA_W'($urandom_range(1, 12));
      endcase
      write_reg(CFG_DECIM, cfg_word);
      // unused upper bits carry noise
      cfg_word = CFG_DATA_W'($urandom);
      cfg_word[STAGES_W-1:0] = STAGES_W'($urandom_range(7));
      write_reg(CFG_STAGES, cfg_word);
      cfg_word = CFG_DATA_W'($urandom);
      cfg_word[DELAY_W-1:0] = DELAY_W'($urandom_range(3));
      write_reg(CFG_DELAY, cfg_word);

      for (int i = 0; i < ROUND_BEATS; i++) begin
        // in round 5, halfway, the sender holds off until the result queue is empty
        if (rnd == 5 && i == ROUND_BEATS / 2) begin
          in_tvalid <= 1'b0;
          @(negedge clk);
          while (pending_cnt != 0) @(negedge clk);
        end
        case ($urandom_range(3))
          0:       sample = $urandom_range(64) - 32;
          1:       sample = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: sample = $urandom;
        endcase
        send_sample(sample);
      end
    end

    drain_results();
    if (fail_cnt == 0) begin
      $display("[cic_multistage_decimator_core] OK");
    end else begin
      $display("[cic_multistage_decimator_core] ERROR");
    end
    $finish;
  end

endmodule
